[rtl/tvc_pkg.sv]
// Shared types and constants of the teleop velocity conditioner.
package tvc_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SMOOTH_XB  = 8;
  localparam int unsigned SMOOTH_W   = SAMPLE_W + SMOOTH_XB;
  localparam int unsigned NAXES      = 6;
  localparam int unsigned GROUP_AXES = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DZ_W       = 15;
  localparam int unsigned MAXMAG_W   = 15;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned COAST_W    = 8;

  // item kinds
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_BUTTON = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MAG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COAST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_LOCK = 3'd4;

  // configuration reset values
  localparam logic [DZ_W-1:0]     DEADZONE_RST = 15'd205;
  localparam logic [MAXMAG_W-1:0] MAX_MAG_RST  = 15'd4096;
  localparam logic [GAIN_W-1:0]   GAIN_RST     = 16'd13107;
  localparam logic [COAST_W-1:0]  COAST_RST    = 8'd6;
  localparam logic                AXIS_LOCK_RST = 1'b1;

  localparam logic [COAST_W-1:0]  TICKS_SAT    = 8'hFF;

  typedef enum logic [2:0] {
    MODE_BOTH = 3'b001,
    MODE_LIN  = 3'b010,
    MODE_ANG  = 3'b100
  } mode_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SMOOTH_W-1:0] smooth_t;
  typedef sample_t [NAXES-1:0] axes_t;
  typedef smooth_t [NAXES-1:0] smooth_axes_t;

  typedef struct packed {
    logic [1:0]          command;
    logic signed [15:0]  lin_x;
    logic signed [15:0]  lin_y;
    logic signed [15:0]  lin_z;
    logic signed [15:0]  ang_x;
    logic signed [15:0]  ang_y;
    logic signed [15:0]  ang_z;
    logic                mode_button;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_lin_x;
    logic signed [15:0] out_lin_y;
    logic signed [15:0] out_lin_z;
    logic signed [15:0] out_ang_x;
    logic signed [15:0] out_ang_y;
    logic signed [15:0] out_ang_z;
  } res_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[rtl/tvc_shaper.sv]
// Deadzone, clamp and dominant-axis lock of one velocity sample.
module tvc_shaper (
  input  tvc_pkg::axes_t                   raw_i,
  input  logic [tvc_pkg::DZ_W-1:0]         deadzone_i,
  input  logic [tvc_pkg::MAXMAG_W-1:0]     max_mag_i,
  input  logic                             lock_en_i,
  output tvc_pkg::axes_t                   shaped_o
);

  function automatic logic [tvc_pkg::SAMPLE_W-1:0] mag_of(input logic [tvc_pkg::SAMPLE_W-1:0] v);
    logic [tvc_pkg::SAMPLE_W-1:0] m;
    m = v[tvc_pkg::SAMPLE_W-1] ? (~v + 1'b1) : v;
    return m;
  endfunction

  function automatic logic [tvc_pkg::SAMPLE_W-1:0] condition(
    input logic [tvc_pkg::SAMPLE_W-1:0] v,
    input logic [tvc_pkg::DZ_W-1:0]     dz,
    input logic [tvc_pkg::MAXMAG_W-1:0] mx
  );
    logic signed [tvc_pkg::SAMPLE_W:0] v_ext;
    logic signed [tvc_pkg::SAMPLE_W:0] mx_pos;
    logic signed [tvc_pkg::SAMPLE_W:0] mx_neg;
    logic [tvc_pkg::SAMPLE_W-1:0]      res;
    v_ext  = $signed({v[tvc_pkg::SAMPLE_W-1], v});
    mx_pos = $signed({2'b00, mx});
    mx_neg = -mx_pos;
    if (mag_of(v) < {1'b0, dz}) begin
      res = '0;
    end else if (v_ext > mx_pos) begin
      res = mx_pos[tvc_pkg::SAMPLE_W-1:0];
    end else if (v_ext < mx_neg) begin
      res = mx_neg[tvc_pkg::SAMPLE_W-1:0];
    end else begin
      res = v;
    end
    return res;
  endfunction

  tvc_pkg::axes_t cond;

  always_comb begin
    logic [1:0] best;
    logic [tvc_pkg::SAMPLE_W-1:0] best_mag;
    for (int i = 0; i < tvc_pkg::NAXES; i++) begin
      cond[i] = condition(raw_i[i], deadzone_i, max_mag_i);
    end
    shaped_o = cond;
    // when the lock is enabled, keep only the largest axis of each group, lowest index wins ties
    for (int g = 0; g < tvc_pkg::NAXES / tvc_pkg::GROUP_AXES; g++) begin
      best     = 2'd0;
      best_mag = mag_of(cond[g * tvc_pkg::GROUP_AXES]);
      for (int k = 1; k < tvc_pkg::GROUP_AXES; k++) begin
        if (mag_of(cond[g * tvc_pkg::GROUP_AXES + k]) > best_mag) begin
          best     = 2'(k);
          best_mag = mag_of(cond[g * tvc_pkg::GROUP_AXES + k]);
        end
      end
      if (lock_en_i) begin
        for (int k = 0; k < tvc_pkg::GROUP_AXES; k++) begin
          if (best != 2'(k)) begin
            shaped_o[g * tvc_pkg::GROUP_AXES + k] = '0;
          end
        end
      end
    end
  end

endmodule

[rtl/tvc_smoother.sv]
// One axis of the exponential smoother, Q3.20 state.
module tvc_smoother (
  input  tvc_pkg::smooth_t                 s_i,
  input  tvc_pkg::sample_t                 held_i,
  input  logic [tvc_pkg::GAIN_W-1:0]       gain_i,
  output tvc_pkg::smooth_t                 s_next_o
);

  localparam int unsigned DIFF_W = tvc_pkg::SMOOTH_W + 1;
  localparam int unsigned PROD_W = DIFF_W + tvc_pkg::GAIN_W + 1;
  localparam int unsigned STEP_W = PROD_W - tvc_pkg::GAIN_W;

  logic signed [tvc_pkg::SMOOTH_W-1:0] target;
  logic signed [DIFF_W-1:0]            diff;
  logic signed [PROD_W-1:0]            prod;
  logic signed [STEP_W-1:0]            step;
  logic signed [STEP_W-1:0]            sum;

  assign target = $signed({held_i, {tvc_pkg::SMOOTH_XB{1'b0}}});
  assign diff   = $signed({target[tvc_pkg::SMOOTH_W-1], target})
                - $signed({s_i[tvc_pkg::SMOOTH_W-1], s_i});
  assign prod   = $signed({1'b0, gain_i}) * diff;
  // floor of alpha * diff / 65536
  assign step   = prod[PROD_W-1:tvc_pkg::GAIN_W];
  assign sum    = $signed({{(STEP_W - tvc_pkg::SMOOTH_W){s_i[tvc_pkg::SMOOTH_W-1]}}, s_i})
                + step;

  // a released axis drops straight to zero
  assign s_next_o = (held_i == '0) ? '0 : sum[tvc_pkg::SMOOTH_W-1:0];

endmodule

[rtl/tvc_res_fifo.sv]
// Two-entry result buffer that decouples the output stall from the input side.
module tvc_res_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tvc_pkg::res_item_t    push_data_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output tvc_pkg::res_item_t    out_data_o,
  output tvc_pkg::fifo_stat_t   stat_o
);

  localparam int unsigned DEPTH = 2;

  tvc_pkg::res_item_t entry_q [DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = out_valid_o & ~out_stall_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'(DEPTH));
  assign stat_o.empty = (cnt_q == 2'd0);

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/teleop_velocity_conditioner.sv]
// An accepted item waits in the input register until the result buffer has room
// and is processed then; the result of an emitting tick enters the result buffer,
// which offers it to the output. Throughput: one item per cycle while the result
// buffer is not full, set by the single-pass datapath between the input register
// and the two-entry result buffer (one 17x25 multiply per axis).
// Reset: asynchronous, active low; clears state and loads config reset values.
module teleop_velocity_conditioner (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tvc_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tvc_pkg::res_item_t                 out_data_o,
  input  logic                               cfg_we_i,
  input  logic [tvc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tvc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [tvc_pkg::DZ_W-1:0]     deadzone_q;
  logic [tvc_pkg::MAXMAG_W-1:0] max_mag_q;
  logic [tvc_pkg::GAIN_W-1:0]   gain_q;
  logic [tvc_pkg::COAST_W-1:0]  coast_q;
  logic                         lock_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q <= tvc_pkg::DEADZONE_RST;
      max_mag_q  <= tvc_pkg::MAX_MAG_RST;
      gain_q     <= tvc_pkg::GAIN_RST;
      coast_q    <= tvc_pkg::COAST_RST;
      lock_en_q  <= tvc_pkg::AXIS_LOCK_RST;
    end else if (cfg_we_i) begin
      // keep only the low bits of each register; drop writes beyond the list
      unique case (cfg_idx_i)
        tvc_pkg::REG_DEADZONE:  deadzone_q <= cfg_data_i[tvc_pkg::DZ_W-1:0];
        tvc_pkg::REG_MAX_MAG:   max_mag_q  <= cfg_data_i[tvc_pkg::MAXMAG_W-1:0];
        tvc_pkg::REG_GAIN:      gain_q     <= cfg_data_i[tvc_pkg::GAIN_W-1:0];
        tvc_pkg::REG_COAST:     coast_q    <= cfg_data_i[tvc_pkg::COAST_W-1:0];
        tvc_pkg::REG_AXIS_LOCK: lock_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: one item waits here until the result buffer has room.
  // The stall comes from registers only, so the input side never sees a
  // combinational path from the output stall.
  // ---------------------------------------------------------------------------
  tvc_pkg::fifo_stat_t fifo_stat;
  tvc_pkg::in_item_t   s1_data_q;
  logic                s1_valid_q, s1_valid_d;
  logic                in_xfer;
  logic                adv;

  assign in_stall_o = s1_valid_q & fifo_stat.full;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign adv        = s1_valid_q & ~fifo_stat.full;
  assign s1_valid_d = in_xfer | (s1_valid_q & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
  end

  logic is_sample, is_button, is_tick;
  assign is_sample = (s1_data_q.command == tvc_pkg::CMD_SAMPLE);
  assign is_button = (s1_data_q.command == tvc_pkg::CMD_BUTTON);
  assign is_tick   = (s1_data_q.command == tvc_pkg::CMD_TICK);

  // ---------------------------------------------------------------------------
  // Sample conditioning: deadzone, clamp, dominant-axis lock
  // ---------------------------------------------------------------------------
  tvc_pkg::axes_t raw_axes;
  tvc_pkg::axes_t shaped;
  tvc_pkg::axes_t held_q;

  assign raw_axes = {s1_data_q.ang_z, s1_data_q.ang_y, s1_data_q.ang_x,
                     s1_data_q.lin_z, s1_data_q.lin_y, s1_data_q.lin_x};

  tvc_shaper u_shaper (
    .raw_i      (raw_axes),
    .deadzone_i (deadzone_q),
    .max_mag_i  (max_mag_q),
    .lock_en_i  (lock_en_q),
    .shaped_o   (shaped)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (adv && is_sample) begin
      held_q <= shaped;
    end
  end

  // ---------------------------------------------------------------------------
  // Mode button: a rising level advances both -> linear -> angular -> both
  // ---------------------------------------------------------------------------
  tvc_pkg::mode_e mode_q, mode_d;
  logic           last_btn_q;

  always_comb begin
    mode_d = mode_q;
    if (s1_data_q.mode_button && !last_btn_q) begin
      unique case (mode_q)
        tvc_pkg::MODE_BOTH: mode_d = tvc_pkg::MODE_LIN;
        tvc_pkg::MODE_LIN:  mode_d = tvc_pkg::MODE_ANG;
        tvc_pkg::MODE_ANG:  mode_d = tvc_pkg::MODE_BOTH;
        default:            mode_d = tvc_pkg::MODE_BOTH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= tvc_pkg::MODE_BOTH;
      last_btn_q <= 1'b0;
    end else if (adv && is_button) begin
      mode_q     <= mode_d;
      last_btn_q <= s1_data_q.mode_button;
    end
  end

  // ---------------------------------------------------------------------------
  // Tick: input detection and coast window
  // ---------------------------------------------------------------------------
  logic [tvc_pkg::COAST_W-1:0] ticks_q, ticks_d;
  logic                        seen_q, seen_d;
  logic                        held_live;
  logic                        emit;

  assign held_live = (held_q != '0);

  always_comb begin
    ticks_d = ticks_q;
    seen_d  = seen_q;
    if (held_live) begin
      ticks_d = '0;
      seen_d  = 1'b1;
      emit    = 1'b1;
    end else begin
      // count ticks without input once some input was seen, saturate at the top
      if (seen_q && (ticks_q != tvc_pkg::TICKS_SAT)) begin
        ticks_d = ticks_q + 1'b1;
      end
      emit = seen_q & (ticks_d < coast_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= '0;
      seen_q  <= 1'b0;
    end else if (adv && is_tick) begin
      ticks_q <= ticks_d;
      seen_q  <= seen_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Smoother: six parallel multiply-adds, updated only on an emitting tick
  // ---------------------------------------------------------------------------
  tvc_pkg::smooth_axes_t smooth_q;
  tvc_pkg::smooth_axes_t smooth_next;

  for (genvar a = 0; a < tvc_pkg::NAXES; a++) begin : g_axis
    tvc_smoother u_smoother (
      .s_i      (smooth_q[a]),
      .held_i   (held_q[a]),
      .gain_i   (gain_q),
      .s_next_o (smooth_next[a])
    );
  end

  logic push;
  assign push = adv & is_tick & emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
    end else if (push) begin
      smooth_q <= smooth_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result: truncate Q3.20 to Q3.12, zero the group the mode leaves out
  // ---------------------------------------------------------------------------
  logic               pub_lin, pub_ang;
  tvc_pkg::res_item_t res;

  assign pub_lin = (mode_q != tvc_pkg::MODE_ANG);
  assign pub_ang = (mode_q != tvc_pkg::MODE_LIN);

  always_comb begin
    res.out_lin_x = pub_lin ? smooth_next[0][tvc_pkg::SMOOTH_W-1:tvc_pkg::SMOOTH_XB] : '0;
    res.out_lin_y = pub_lin ? smooth_next[1][tvc_pkg::SMOOTH_W-1:tvc_pkg::SMOOTH_XB] : '0;
    res.out_lin_z = pub_lin ? smooth_next[2][tvc_pkg::SMOOTH_W-1:tvc_pkg::SMOOTH_XB] : '0;
    res.out_ang_x = pub_ang ? smooth_next[3][tvc_pkg::SMOOTH_W-1:tvc_pkg::SMOOTH_XB] : '0;
    res.out_ang_y = pub_ang ? smooth_next[4][tvc_pkg::SMOOTH_W-1:tvc_pkg::SMOOTH_XB] : '0;
    res.out_ang_z = pub_ang ? smooth_next[5][tvc_pkg::SMOOTH_W-1:tvc_pkg::SMOOTH_XB] : '0;
  end

  tvc_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .stat_o      (fifo_stat)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_stat.full)
    else $error("result pushed into a full buffer");

  a_input_tick_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && is_tick && held_live) |=> (seen_q && ticks_q == '0))
    else $error("tick with input did not restart the coast window");

  a_ticks_need_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ticks_q != '0) |-> seen_q)
    else $error("coast counter moved before any input");

  a_valid_falls_on_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_valid_o && !out_stall_i))
    else $error("result withdrawn without a transfer");
`endif

endmodule
